@@ rtl/rlzd_pkg.sv @@
// ----------------------------------------------------------------------------
// rlzd_pkg: shared types and constants for the run / back-reference decoder
// Holds the payload structs, the controller/datapath interface structs and
// the fixed sizes of the history window and the position counter.
// ----------------------------------------------------------------------------
package rlzd_pkg;

	// History window: 4096 entries of 5-bit values.
	localparam int WIN_DEPTH = 4096;
	localparam int WIN_BITS  = 12;
	localparam int VAL_BITS  = 5;

	// Plane position counter and the mask applied to the reported position.
	localparam int CNT_BITS      = 24;
	localparam int POSITION_BITS = 24;
	localparam logic [CNT_BITS-1:0] POS_MASK = (POSITION_BITS >= CNT_BITS) ? '1 :
		CNT_BITS'((64'd1 << POSITION_BITS) - 64'd1);

	// Byte decoding constants.
	localparam logic [7:0] REF_MIN      = 8'h80;
	localparam logic [3:0] MIN_COPY_LEN = 4'd3;
	localparam logic [3:0] MIN_RUN_LEN  = 4'd1;

	// Remaining-length counter, holds up to ten.
	localparam int REM_BITS = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_req;
	} in_item_t;

	typedef struct packed {
		logic [VAL_BITS-1:0] value;
		logic [CNT_BITS-1:0] position;
		logic                last;
	} out_item_t;

	// What the byte at the input decodes to.
	typedef enum logic [1:0] {
		DEC_RUN,
		DEC_COPY,
		DEC_OPEN
	} dec_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_PREP,
		ST_COPY
	} ctrl_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;
		logic emit_run;
		logic emit_copy;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		dec_kind_t dec_kind;
		logic      can_load;
		logic      at_limit;
		logic      last_one;
	} dp_status_t;

endpackage

@@ rtl/rlzd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rlzd_ctrl: sequencing state machine
// Accepts one byte at a time, then steps the datapath through a run or a
// back-reference copy, one emitted value per cycle while the output is free.
// ----------------------------------------------------------------------------
module rlzd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rlzd_pkg::dp_status_t status,
	output rlzd_pkg::dp_cmd_t    cmd
);
	import rlzd_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.accept    = 1'b0;
		cmd.emit_run  = 1'b0;
		cmd.emit_copy = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (status.dec_kind)
						DEC_RUN:  state_d = ST_RUN;
						DEC_COPY: state_d = ST_PREP;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_RUN: begin
				if (status.at_limit) begin
					state_d = ST_IDLE;
				end else if (status.can_load) begin
					cmd.emit_run = 1'b1;
					if (status.last_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_PREP: begin
				// The first source read is issued in this cycle.
				state_d = ST_COPY;
			end
			ST_COPY: begin
				if (status.at_limit) begin
					state_d = ST_IDLE;
				end else if (status.can_load) begin
					cmd.emit_copy = 1'b1;
					if (status.last_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// A value is only produced into a free output register.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_run || cmd.emit_copy) |-> status.can_load)
		else $error("emit while output register is occupied");

	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.emit_run, cmd.emit_copy}))
		else $error("conflicting datapath commands");

	a_prep_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) |=> (state_q == ST_COPY))
		else $error("read setup not followed by copy");

endmodule

@@ rtl/rlzd_datapath.sv @@
// ----------------------------------------------------------------------------
// rlzd_datapath: decode registers, history memory and output register
// Decodes accepted bytes, keeps the plane position, reads the history window
// one value ahead of the copy and holds each result until it is taken.
// ----------------------------------------------------------------------------
module rlzd_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rlzd_pkg::in_item_t               in_data,
	output rlzd_pkg::out_item_t              out_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	input  logic                             cfg_we,
	input  logic [rlzd_pkg::CNT_BITS-1:0]    cfg_wdata,
	input  rlzd_pkg::dp_cmd_t                cmd,
	output rlzd_pkg::dp_status_t             status
);
	import rlzd_pkg::*;

	logic [CNT_BITS-1:0] limit_q;
	logic [CNT_BITS-1:0] count_q;
	logic [CNT_BITS-1:0] count_d;
	logic                pend_valid_q;
	logic [6:0]          pend_high_q;
	logic [REM_BITS-1:0] rem_q;
	logic [VAL_BITS-1:0] run_val_q;
	logic [WIN_BITS:0]   dist_q;
	logic                out_valid_q;
	out_item_t           out_data_q;

	logic                pend_eff;
	logic [14:0]         ref_word;
	logic                emit;
	logic [VAL_BITS-1:0] emit_val;
	logic [CNT_BITS:0]   src_diff;
	logic [WIN_BITS-1:0] rd_addr;

	logic [VAL_BITS-1:0] hist_mem [WIN_DEPTH];
	logic [VAL_BITS-1:0] rd_mem_q;
	logic                fwd_q;
	logic [VAL_BITS-1:0] fwd_data_q;
	logic                below_q;

	// Byte classification; a start of plane drops any half-read reference.
	assign pend_eff = pend_valid_q && !in_data.start_req;
	assign ref_word = {pend_high_q, in_data.in_byte};

	always_comb begin
		if (pend_eff) begin
			status.dec_kind = DEC_COPY;
		end else if (in_data.in_byte < REF_MIN) begin
			status.dec_kind = DEC_RUN;
		end else begin
			status.dec_kind = DEC_OPEN;
		end
	end

	assign emit            = cmd.emit_run || cmd.emit_copy;
	assign status.can_load = !out_valid_q || out_ready;
	assign status.at_limit = (count_q >= limit_q);
	assign status.last_one = (rem_q == REM_BITS'(1)) || ((count_q + CNT_BITS'(1)) == limit_q);

	// Next plane position.
	always_comb begin
		if (cmd.accept && in_data.start_req) begin
			count_d = '0;
		end else if (emit) begin
			count_d = count_q + CNT_BITS'(1);
		end else begin
			count_d = count_q;
		end
	end

	// Source of the next copied value; a borrow means before the plane start.
	assign src_diff = {1'b0, count_d} - (CNT_BITS+1)'(dist_q);
	assign rd_addr  = src_diff[WIN_BITS-1:0];

	// Value produced this cycle.
	always_comb begin
		if (cmd.emit_run) begin
			emit_val = run_val_q;
		end else if (below_q) begin
			emit_val = '0;
		end else if (fwd_q) begin
			emit_val = fwd_data_q;
		end else begin
			emit_val = rd_mem_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q      <= '0;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			rem_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			count_q <= count_d;
			if (cmd.accept) begin
				unique case (status.dec_kind)
					DEC_COPY: begin
						pend_valid_q <= 1'b0;
						rem_q        <= {1'b0, ref_word[14:12]} + MIN_COPY_LEN;
					end
					DEC_RUN: begin
						pend_valid_q <= 1'b0;
						rem_q        <= {2'b00, in_data.in_byte[6:5]} + MIN_RUN_LEN;
					end
					default: begin
						pend_valid_q <= 1'b1;
					end
				endcase
			end else if (emit) begin
				rem_q <= rem_q - REM_BITS'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_high_q <= in_data.in_byte[6:0];
			run_val_q   <= in_data.in_byte[VAL_BITS-1:0];
			dist_q      <= (WIN_BITS+1)'(WIN_DEPTH) - {1'b0, ref_word[WIN_BITS-1:0]};
		end
		if (emit) begin
			out_data_q.value    <= emit_val;
			out_data_q.position <= count_q & POS_MASK;
			out_data_q.last     <= status.last_one;
		end
	end

	// History memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (emit) begin
			hist_mem[count_q[WIN_BITS-1:0]] <= emit_val;
		end
		rd_mem_q <= hist_mem[rd_addr];
	end

	// Forward a value written in the same cycle it is read back.
	always_ff @(posedge clk) begin
		fwd_q      <= emit && (count_q[WIN_BITS-1:0] == rd_addr);
		fwd_data_q <= emit_val;
		below_q    <= src_diff[CNT_BITS];
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_emit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (count_q < limit_q))
		else $error("value emitted past the plane limit");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (count_q == CNT_BITS'($past(count_q) + CNT_BITS'(1))))
		else $error("position did not advance on emit");

	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (rem_q != '0))
		else $error("emit with no remaining length");

endmodule

@@ rtl/rle_lz_window_decoder.sv @@
// ----------------------------------------------------------------------------
// rle_lz_window_decoder: run-length and back-reference plane decoder
// Turns a compressed byte stream into 5-bit plane values with a 4096-entry
// history window.
//
//   port group  direction  handshake          payload
//   in_*        input      in_valid/in_ready  in_item_t  (in_byte, start_req)
//   out_*       output     out_valid/out_ready out_item_t (value, position, last)
//   cfg_*       input      cfg_we             out_limit, 24 bits
//
// A run byte yields n values (n up to 4); the first byte of a back reference
// yields none; the second yields n values (n up to 10), after a first history
// read in the PREP state. When the plane limit is already reached, a run byte
// or a second reference byte yields none. A new byte is taken only when idle.
// One value per cycle, while the output is free, is set by the single output
// register and the single history write port.
// Reset clears control state and out_limit; the history memory is not cleared.
// An output stall holds the current value and pauses the run or copy.
// ----------------------------------------------------------------------------
module rle_lz_window_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  rlzd_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rlzd_pkg::out_item_t            out_data,
	input  logic                           cfg_we,
	input  logic [rlzd_pkg::CNT_BITS-1:0]  cfg_wdata
);
	import rlzd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer.
	rlzd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Decode, history and output datapath.
	rlzd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

@@ sim/tb_rle_lz_window_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_rle_lz_window_decoder: self-checking bench for the plane decoder
// Feeds compressed bytes through the input handshake and decodes the same bytes
// in a behavioral model of runs, back references, the history window and the
// plane limit. Every output transaction is compared with the oldest predicted
// value. Both handshakes stall at random, and one plane runs with no stalls,
// with long copies and copies from close to the full window
// distance.
// ----------------------------------------------------------------------------
module tb_rle_lz_window_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import rlzd_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 32;
	localparam int REPORT_MAX    = 10;
	localparam logic [CNT_BITS-1:0] LIMIT_MAX = '1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	in_item_t            in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_item_t           out_data;
	logic                cfg_we = 1'b0;
	logic [CNT_BITS-1:0] cfg_wdata = '0;

	// Bytes still to be offered, and decoded values still to arrive.
	in_item_t  byte_q[$];
	out_item_t decoded_q[$];

	// Model state: window, plane position, half-open reference, limit.
	logic [VAL_BITS-1:0] window_mem [WIN_DEPTH];
	int                  plane_pos = 0;
	logic [6:0]          ref_high = '0;
	logic                ref_open = 1'b0;
	int                  plane_limit = 0;

	int        stall_pct = 25;
	int        mismatch_count = 0;
	int        quiet_cycles = 0;
	logic      byte_taken = 1'b0;
	out_item_t want;

	rle_lz_window_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Records one decoded value in the window and in the expected stream.
	task automatic store_value(input logic [VAL_BITS-1:0] v);
		decoded_q.push_back('{value: v, position: CNT_BITS'(plane_pos) & POS_MASK,
			last: 1'b0});
		window_mem[WIN_BITS'(plane_pos)] = v;
		plane_pos++;
	endtask

	// Decodes one accepted byte and appends the values it yields.
	task automatic decode_byte(input in_item_t item);
		logic [14:0]         word;
		logic [VAL_BITS-1:0] v;
		int                  len;
		int                  ref_dist;
		int                  produced;
		produced = 0;
		if (item.start_req) begin
			plane_pos = 0;
			ref_open = 1'b0;
		end
		if (ref_open) begin
			word = {ref_high, item.in_byte};
			len = int'(word[14:12]) + int'(MIN_COPY_LEN);
			ref_dist = WIN_DEPTH - int'(word[11:0]);
			ref_open = 1'b0;
			// Value by value, so an overlapping copy sees its own output.
			for (int i = 0; i < len && plane_pos < plane_limit; i++) begin
				v = (plane_pos >= ref_dist) ?
					window_mem[WIN_BITS'(plane_pos - ref_dist)] : '0;
				store_value(v);
				produced++;
			end
		end else if (item.in_byte < REF_MIN) begin
			len = int'(item.in_byte[6:5]) + int'(MIN_RUN_LEN);
			for (int i = 0; i < len && plane_pos < plane_limit; i++) begin
				store_value(item.in_byte[VAL_BITS-1:0]);
				produced++;
			end
		end else begin
			ref_high = item.in_byte[6:0];
			ref_open = 1'b1;
		end
		if (produced > 0)
			decoded_q[decoded_q.size()-1].last = 1'b1;
	endtask

	function automatic void queue_byte(input logic [7:0] b, input logic s);
		byte_q.push_back('{in_byte: b, start_req: s});
	endfunction

	// Mostly well-formed runs and reference pairs, with some new-plane bytes
	// that may cut a reference in half.
	function automatic void queue_random(input int steps, input int plane_pct);
		int r;
		for (int k = 0; k < steps; k++) begin
			r = $urandom_range(99);
			if (r < plane_pct) begin
				queue_byte(8'($urandom_range(255)), 1'b1);
			end else if (r < 55) begin
				queue_byte({1'b0, 7'($urandom_range(127))}, 1'b0);
			end else begin
				queue_byte({1'b1, 7'($urandom_range(127))}, 1'b0);
				queue_byte(8'($urandom_range(255)), 1'b0);
			end
		end
	endfunction

	// Waits until every byte is taken and every value has come out, then
	// gives the block time to finish a byte that yields nothing.
	task automatic settle();
		while (byte_q.size() != 0 || decoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CNT_BITS-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Input driver and output back-pressure, both updated on the falling edge.
	always @(negedge clk) begin : drive_inputs
		logic     next_valid;
		in_item_t next_item;
		next_valid = in_valid;
		next_item = in_data;
		if (byte_taken) begin
			void'(byte_q.pop_front());
			next_valid = 1'b0;
		end
		if (arst_n && !next_valid && byte_q.size() != 0 &&
				$urandom_range(99) >= stall_pct) begin
			next_valid = 1'b1;
			next_item = byte_q[0];
		end
		in_valid <= next_valid;
		in_data <= next_item;
		out_ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// Samples both handshakes at the rising edge, predicts and checks.
	always @(posedge clk) begin
		byte_taken = arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (cfg_we)
				plane_limit = int'(cfg_wdata);
			if (byte_taken)
				decode_byte(in_data);
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("unexpected transaction: value %0d position %0d last %0b",
							out_data.value, out_data.position, out_data.last);
				end else begin
					want = decoded_q.pop_front();
					if (out_data.value !== want.value || out_data.position !== want.position ||
							out_data.last !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX)
							$display("mismatch: expected value %0d position %0d last %0b, %s %0d %0d %0b",
								want.value, want.position, want.last, "got",
								out_data.value, out_data.position, out_data.last);
					end
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves a transaction.
	always @(posedge clk) begin
		if (arst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_limit(LIMIT_MAX);

		// Runs of every length, field extremes, copies before the plane start,
		// overlapping copies, and a reference cut off by a new plane.
		queue_byte(8'h00, 1'b1);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'h45, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h8F, 1'b0);
		queue_byte(8'hFE, 1'b0);
		queue_byte(8'hB0, 1'b0);
		queue_byte(8'h07, 1'b0);
		queue_byte(8'h85, 1'b0);
		queue_byte(8'h3F, 1'b1);
		queue_byte(8'hC3, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hEF, 1'b0);
		queue_byte(8'hFD, 1'b0);
		settle();

		// A run and a copy cut short at the limit, then a byte past it.
		write_limit(24'd5);
		queue_byte(8'h7F, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h21, 1'b0);
		settle();

		// The limit lowered below the current count, then a limit of zero.
		write_limit(24'd2);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h9F, 1'b0);
		queue_byte(8'hFF, 1'b0);
		settle();
		write_limit(24'd0);
		queue_byte(8'h7F, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		settle();

		// Random planes under a moderate limit.
		write_limit(24'($urandom_range(40, 300)));
		queue_byte(8'($urandom_range(127)), 1'b1);
		queue_random(20, 8);
		settle();

		// One plane with no stalls: runs, long copies, then copies from close
		// to the full window distance.
		stall_pct = 0;
		write_limit(LIMIT_MAX);
		queue_byte(8'($urandom_range(127)), 1'b1);
		for (int k = 0; k < 8; k++)
			queue_byte({1'b0, 7'($urandom_range(127))}, 1'b0);
		for (int k = 0; k < 10; k++) begin
			queue_byte({4'hF, 4'($urandom_range(15))}, 1'b0);
			queue_byte(8'($urandom_range(255)), 1'b0);
		end
		for (int k = 0; k < 3; k++) begin
			queue_byte({1'b1, 3'($urandom_range(7)), 4'h0}, 1'b0);
			queue_byte(8'($urandom_range(255)), 1'b0);
		end
		settle();

		// Short limits with frequent new planes.
		stall_pct = 25;
		for (int p = 0; p < 3; p++) begin
			write_limit(24'($urandom_range(0, 24)));
			queue_random(6, 15);
			settle();
		end

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
